// File: src/adcf_pkg.sv
// Shared types and constants for the associative data cache.
// No dependencies; every other file of the block depends on this package.
`default_nettype none

package adcf_pkg;

  localparam int unsigned LINES_DEFAULT = 16;
  localparam int unsigned ACTION_W      = 2;
  localparam int unsigned ADDR_W        = 32;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned LINE_W        = 4;
  localparam int unsigned CFG_W         = 5;
  localparam int unsigned QDEPTH        = 2;

  localparam logic [CFG_W-1:0] LINES_IN_USE_RESET = 5'd16;

  localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_FILL   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_LOOKUP,
    OP_FILL,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t                      op;
    logic [ADDR_W-1:0]        address;
    logic signed [DATA_W-1:0] write_data;
  } req_t;

endpackage

`default_nettype wire

// File: src/adcf_if.sv
// Valid/ready channel interfaces for request, response and configuration.
// Depends on adcf_pkg for field widths.
`default_nettype none

interface adcf_req_if;
  logic                                       valid;
  logic                                       ready;
  logic [adcf_pkg::ACTION_W-1:0]              action;
  logic [adcf_pkg::ADDR_W-1:0]                address;
  logic signed [adcf_pkg::DATA_W-1:0]         write_data;
  modport source (output valid, action, address, write_data, input ready);
  modport sink   (input valid, action, address, write_data, output ready);
endinterface

interface adcf_rsp_if;
  logic                                       valid;
  logic                                       ready;
  logic                                       hit;
  logic [adcf_pkg::LINE_W-1:0]                hit_line;
  logic signed [adcf_pkg::DATA_W-1:0]         read_data;
  modport source (output valid, hit, hit_line, read_data, input ready);
  modport sink   (input valid, hit, hit_line, read_data, output ready);
endinterface

interface adcf_cfg_if;
  logic                                       valid;
  logic                                       ready;
  logic [adcf_pkg::CFG_W-1:0]                 lines_in_use;
  modport source (output valid, lines_in_use, input ready);
  modport sink   (input valid, lines_in_use, output ready);
endinterface

`default_nettype wire

// File: src/adcf_front.sv
// Front end: accepts request items, decodes the action and queues them.
// Depends on adcf_pkg and adcf_req_if.
`default_nettype none

module adcf_front (
  input  wire logic          clk,
  input  wire logic          rst,
  adcf_req_if.sink           req,
  output adcf_pkg::req_t     q_req,
  output logic               q_valid,
  input  wire logic          q_pop
);
  import adcf_pkg::*;

  localparam int unsigned QP_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QC_W = $clog2(QDEPTH + 1);

  req_t             queue [QDEPTH];
  logic [QP_W-1:0]  wr_ptr;
  logic [QP_W-1:0]  rd_ptr;
  logic [QC_W-1:0]  count;
  logic             push;
  req_t             decoded;

  always_comb begin
    decoded.address    = req.address;
    decoded.write_data = req.write_data;
    unique case (req.action)
      ACT_LOOKUP: decoded.op = OP_LOOKUP;
      ACT_FILL:   decoded.op = OP_FILL;
      ACT_CLEAR:  decoded.op = OP_CLEAR;
      default:    decoded.op = OP_NOP;
    endcase
  end

  assign req.ready = (count != QC_W'(QDEPTH));
  assign push      = req.valid && req.ready;
  assign q_valid   = (count != '0);
  assign q_req     = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QP_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == QP_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= decoded;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QC_W'(QDEPTH))
    else $error("queue count above depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> count != '0)
    else $error("pop from empty queue");
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    push && !q_pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not advance on push");
`endif

endmodule

`default_nettype wire

// File: src/adcf_back.sv
// Back end: tag compare, line fill and clear, holds the result register.
// Depends on adcf_pkg, adcf_cfg_if and adcf_rsp_if.
`default_nettype none

module adcf_back #(
  parameter int unsigned LINES = adcf_pkg::LINES_DEFAULT
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire adcf_pkg::req_t  q_req,
  input  wire logic            q_valid,
  output logic                 q_pop,
  adcf_cfg_if.sink             cfg,
  adcf_rsp_if.source           rsp
);
  import adcf_pkg::*;

  localparam int unsigned PTR_W = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int unsigned CNT_W = $clog2(LINES + 1);
  localparam int unsigned CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic [CFG_W-1:0]   lines_in_use;
  logic [CNT_W-1:0]   n_active;
  logic [ADDR_W-1:0]  line_tag [LINES];
  logic [DATA_W-1:0]  line_value [LINES];
  logic [LINES-1:0]   line_valid;
  logic [PTR_W-1:0]   fill_ptr;
  logic [PTR_W-1:0]   fill_ptr_next;
  logic [PTR_W-1:0]   fill_slot;
  logic [CNT_W-1:0]   slot_inc;
  logic [LINES-1:0]   match;
  logic               hit_any;
  logic [PTR_W-1:0]   hit_idx;
  logic               fire;
  logic               rsp_valid;
  logic               rsp_hit;
  logic [LINE_W-1:0]  rsp_line;
  logic [DATA_W-1:0]  rd_data;

  always_comb begin
    priority if (lines_in_use == '0) begin
      n_active = CNT_W'(1);
    end else if (CMP_W'(lines_in_use) > CMP_W'(LINES)) begin
      n_active = CNT_W'(LINES);
    end else begin
      n_active = CNT_W'(lines_in_use);
    end
  end

  always_comb begin
    for (int i = 0; i < LINES; i++) begin
      match[i] = line_valid[i] && (line_tag[i] == q_req.address)
                 && (CNT_W'(i) < n_active);
    end
  end

  always_comb begin
    hit_idx = '0;
    for (int i = LINES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = PTR_W'(i);
      end
    end
  end

  assign hit_any       = |match;
  assign fill_slot     = (CNT_W'(fill_ptr) >= n_active) ? '0 : fill_ptr;
  assign slot_inc      = CNT_W'(fill_slot) + 1'b1;
  assign fill_ptr_next = (slot_inc >= n_active) ? '0 : PTR_W'(slot_inc);

  assign fire      = q_valid && (!rsp_valid || rsp.ready);
  assign q_pop     = fire;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid    <= 1'b0;
      line_valid   <= '0;
      fill_ptr     <= '0;
      lines_in_use <= LINES_IN_USE_RESET;
    end else begin
      if (cfg.valid) begin
        lines_in_use <= cfg.lines_in_use;
      end
      if (fire) begin
        rsp_valid <= 1'b1;
        unique case (q_req.op)
          OP_FILL: begin
            line_valid[fill_slot] <= 1'b1;
            fill_ptr              <= fill_ptr_next;
          end
          OP_CLEAR: begin
            line_valid <= '0;
            fill_ptr   <= '0;
          end
          default: begin
          end
        endcase
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp_hit  <= (q_req.op == OP_LOOKUP) && hit_any;
      rsp_line <= LINE_W'(hit_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (fire && (q_req.op == OP_FILL)) begin
      line_tag[fill_slot] <= q_req.address;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && (q_req.op == OP_FILL)) begin
      line_value[fill_slot] <= q_req.write_data;
    end
    if (fire) begin
      rd_data <= line_value[hit_idx];
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.hit       = rsp_hit;
  assign rsp.hit_line  = rsp_hit ? rsp_line : '0;
  assign rsp.read_data = rsp_hit ? rd_data : '0;

`ifndef SYNTHESIS
  a_clear_all: assert property (@(posedge clk) disable iff (rst)
    fire && (q_req.op == OP_CLEAR) |=> line_valid == '0 && fill_ptr == '0)
    else $error("clear left a valid line or a nonzero pointer");
  a_fill_valid: assert property (@(posedge clk) disable iff (rst)
    fire && (q_req.op == OP_FILL) |=> line_valid != '0)
    else $error("fill left no valid line");
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    CNT_W'(fill_ptr) < CNT_W'(LINES))
    else $error("fill pointer beyond line count");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.hit |-> rsp.hit_line == '0 && rsp.read_data == '0)
    else $error("miss result carries nonzero fields");
`endif

endmodule

`default_nettype wire

// File: src/assoc_data_cache_fifo.sv
// Fully associative data cache, FIFO replacement, valid/ready channels.
// An item taken into an empty queue passes a queue entry, then the result register.
// Throughput: one item per cycle while the receiver holds rsp.ready; the back end's single
// lookup and value read per cycle set the rate, with a two-entry queue in between.
// Reset (rst, synchronous): all lines invalid, fill pointer zero, 16 lines in use.
// Depends on adcf_pkg, adcf_if, adcf_front and adcf_back.
`default_nettype none

module assoc_data_cache_fifo #(
  parameter int unsigned LINES = adcf_pkg::LINES_DEFAULT
) (
  input  wire logic  clk,
  input  wire logic  rst,
  adcf_req_if.sink   req,
  adcf_rsp_if.source rsp,
  adcf_cfg_if.sink   cfg
);
  import adcf_pkg::*;

  req_t q_req;
  logic q_valid;
  logic q_pop;

  adcf_front u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .q_req   (q_req),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  adcf_back #(
    .LINES (LINES)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_req   (q_req),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .cfg     (cfg),
    .rsp     (rsp)
  );

endmodule

`default_nettype wire

// File: test/tb_assoc_data_cache_fifo.sv
// Self-checking testbench for assoc_data_cache_fifo: directed table, then random phases
// with sender idling, receiver stalls and a long receiver hold-off.
// Depends on adcf_pkg, adcf_if and the assoc_data_cache_fifo RTL.
`default_nettype none

module tb_assoc_data_cache_fifo;
  import adcf_pkg::*;

  localparam int unsigned LINE_COUNT = LINES_DEFAULT;
  localparam logic [ACTION_W-1:0] ACT_RESERVED = 2'd3;
  localparam int unsigned PHASES = 5;
  localparam int unsigned ITEMS_PER_PHASE = 220;
  localparam int unsigned DIR_ROWS = 24;

  typedef struct packed {
    logic                     hit;
    logic [LINE_W-1:0]        hit_line;
    logic signed [DATA_W-1:0] read_data;
  } cache_rsp_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;
  typedef enum logic {BY_MODEL, BY_TABLE} check_src_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [CFG_W-1:0]  cfg_val;
    logic [ACTION_W-1:0] action;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
    check_src_e        src;
    cache_rsp_t        rsp;
  } dir_row_t;

  localparam cache_rsp_t ZERO_RSP = '0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_ITEM, 5'd0,  ACT_LOOKUP,   32'h0000_0000, 32'h0000_0000, BY_TABLE, ZERO_RSP},
    '{ROW_ITEM, 5'd0,  ACT_LOOKUP,   32'hFFFF_FFFF, 32'h0000_0000, BY_TABLE, ZERO_RSP},
    '{ROW_ITEM, 5'd0,  ACT_FILL,     32'h0000_0000, 32'h8000_0000, BY_TABLE, ZERO_RSP},
    '{ROW_ITEM, 5'd0,  ACT_FILL,     32'hFFFF_FFFF, 32'h7FFF_FFFF, BY_TABLE, ZERO_RSP},
    '{ROW_ITEM, 5'd0,  ACT_FILL,     32'h0000_0000, 32'h1234_5678, BY_TABLE, ZERO_RSP},
    '{ROW_ITEM, 5'd0,  ACT_LOOKUP,   32'h0000_0000, 32'h0000_0000, BY_MODEL, ZERO_RSP},
    '{ROW_ITEM, 5'd0,  ACT_LOOKUP,   32'hFFFF_FFFF, 32'hFFFF_FFFF, BY_MODEL, ZERO_RSP},
    '{ROW_ITEM, 5'd0,  ACT_RESERVED, 32'hAAAA_AAAA, 32'h5555_5555, BY_TABLE, ZERO_RSP},
    '{ROW_ITEM, 5'd0,  ACT_FILL,     32'h5555_5555, 32'hAAAA_AAAA, BY_TABLE, ZERO_RSP},
    '{ROW_CFG,  5'd2,  ACT_LOOKUP,   32'h0000_0000, 32'h0000_0000, BY_MODEL, ZERO_RSP},
    '{ROW_ITEM, 5'd0,  ACT_LOOKUP,   32'h5555_5555, 32'h0000_0000, BY_MODEL, ZERO_RSP},
    '{ROW_ITEM, 5'd0,  ACT_FILL,     32'h1111_1111, 32'h0000_0001, BY_TABLE, ZERO_RSP},
    '{ROW_ITEM, 5'd0,  ACT_LOOKUP,   32'h0000_0000, 32'h0000_0000, BY_MODEL, ZERO_RSP},
    '{ROW_CFG,  5'd0,  ACT_LOOKUP,   32'h0000_0000, 32'h0000_0000, BY_MODEL, ZERO_RSP},
    '{ROW_ITEM, 5'd0,  ACT_FILL,     32'h2222_2222, 32'h0000_0002, BY_TABLE, ZERO_RSP},
    '{ROW_ITEM, 5'd0,  ACT_FILL,     32'h3333_3333, 32'h0000_0003, BY_TABLE, ZERO_RSP},
    '{ROW_ITEM, 5'd0,  ACT_LOOKUP,   32'h3333_3333, 32'h0000_0000, BY_MODEL, ZERO_RSP},
    '{ROW_CFG,  5'd31, ACT_LOOKUP,   32'h0000_0000, 32'h0000_0000, BY_MODEL, ZERO_RSP},
    '{ROW_ITEM, 5'd0,  ACT_LOOKUP,   32'h0000_0000, 32'h0000_0000, BY_MODEL, ZERO_RSP},
    '{ROW_ITEM, 5'd0,  ACT_LOOKUP,   32'h5555_5555, 32'h0000_0000, BY_MODEL, ZERO_RSP},
    '{ROW_ITEM, 5'd0,  ACT_CLEAR,    32'hFFFF_FFFF, 32'hFFFF_FFFF, BY_TABLE, ZERO_RSP},
    '{ROW_ITEM, 5'd0,  ACT_LOOKUP,   32'h0000_0000, 32'h0000_0000, BY_TABLE, ZERO_RSP},
    '{ROW_CFG,  5'd16, ACT_LOOKUP,   32'h0000_0000, 32'h0000_0000, BY_MODEL, ZERO_RSP},
    '{ROW_ITEM, 5'd0,  ACT_LOOKUP,   32'h3333_3333, 32'h0000_0000, BY_TABLE, ZERO_RSP}
  };

  int send_idle_pct [PHASES] = '{0, 74, 0, 12, 0};
  int recv_stall_pct [PHASES] = '{0, 0, 74, 12, 0};
  logic [CFG_W-1:0] phase_lines [PHASES] = '{5'd16, 5'd3, 5'd1, 5'd0, 5'd8};

  logic clk = 1'b0;
  logic rst;

  adcf_req_if req_if ();
  adcf_rsp_if rsp_if ();
  adcf_cfg_if cfg_if ();

  assoc_data_cache_fifo dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // cache image
  logic [ADDR_W-1:0] tag_mem [LINE_COUNT];
  logic [DATA_W-1:0] value_mem [LINE_COUNT];
  logic [LINE_COUNT-1:0] line_valid;
  int unsigned fill_ptr;
  logic [CFG_W-1:0] lines_cfg;

  cache_rsp_t expected_rsps [$];
  cache_rsp_t oldest_rsp;
  int errors;
  int items_sent;
  int rsps_checked;
  int hits_seen;
  int cfg_writes;
  int sender_idle;
  int recv_stall;
  int hold_left;

  function automatic cache_rsp_t cache_access(input logic [ACTION_W-1:0] act,
                                              input logic [ADDR_W-1:0] addr,
                                              input logic [DATA_W-1:0] wdata);
    cache_rsp_t r;
    int unsigned n;
    int unsigned p;
    r = ZERO_RSP;
    n = (lines_cfg == 0) ? 1 : ((lines_cfg > LINE_COUNT) ? LINE_COUNT : lines_cfg);
    case (act)
      ACT_LOOKUP: begin
        for (int i = 0; i < n; i++) begin
          if (line_valid[i] && tag_mem[i] == addr) begin
            r.hit = 1'b1;
            r.hit_line = i[LINE_W-1:0];
            r.read_data = value_mem[i];
            break;
          end
        end
      end
      ACT_FILL: begin
        p = (fill_ptr >= n) ? 0 : fill_ptr;
        tag_mem[p] = addr;
        value_mem[p] = wdata;
        line_valid[p] = 1'b1;
        p++;
        fill_ptr = (p >= n) ? 0 : p;
      end
      ACT_CLEAR: begin
        line_valid = '0;
        fill_ptr = 0;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic send_item(input logic [ACTION_W-1:0] act, input logic [ADDR_W-1:0] addr,
                           input logic [DATA_W-1:0] wdata, input check_src_e src,
                           input cache_rsp_t table_rsp);
    cache_rsp_t model_rsp;
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle) begin
      req_if.valid = 1'b0;
      @(negedge clk);
    end
    req_if.valid = 1'b1;
    req_if.action = act;
    req_if.address = addr;
    req_if.write_data = wdata;
    do @(posedge clk); while (!req_if.ready);
    model_rsp = cache_access(act, addr, wdata);
    expected_rsps.push_back((src == BY_TABLE) ? table_rsp : model_rsp);
    items_sent++;
  endtask

  task automatic write_lines_in_use(input logic [CFG_W-1:0] val);
    @(negedge clk);
    req_if.valid = 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    @(negedge clk);
    req_if.valid = 1'b0;
    cfg_if.valid = 1'b1;
    cfg_if.lines_in_use = val;
    do @(posedge clk); while (!cfg_if.ready);
    lines_cfg = val;
    cfg_writes++;
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // receiver: random stalls plus a counted hold-off
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        rsp_if.ready = 1'b0;
        hold_left--;
      end else begin
        rsp_if.ready = ($urandom_range(0, 99) >= recv_stall);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (expected_rsps.size() == 0) begin
        $error("result with no item pending: hit %0d line %0d data %0d",
               rsp_if.hit, rsp_if.hit_line, rsp_if.read_data);
        errors++;
      end else begin
        oldest_rsp = expected_rsps.pop_front();
        rsps_checked++;
        if (rsp_if.hit === 1'b1) hits_seen++;
        if (rsp_if.hit !== oldest_rsp.hit) begin
          $error("hit: expected %0d, actual %0d", oldest_rsp.hit, rsp_if.hit);
          errors++;
        end
        if (rsp_if.hit_line !== oldest_rsp.hit_line) begin
          $error("hit_line: expected %0d, actual %0d", oldest_rsp.hit_line, rsp_if.hit_line);
          errors++;
        end
        if (rsp_if.read_data !== oldest_rsp.read_data) begin
          $error("read_data: expected %0d, actual %0d",
                 oldest_rsp.read_data, rsp_if.read_data);
          errors++;
        end
      end
    end
  end

  initial begin
    #1_000_000;
    $display("assoc_data_cache_fifo test failed");
    $finish;
  end

  initial begin
    logic [ADDR_W-1:0] addr_pool [8];
    logic [ACTION_W-1:0] act;
    logic [ADDR_W-1:0] addr;
    int pick;
    int waited;

    rst = 1'b1;
    req_if.valid = 1'b0;
    req_if.action = ACT_LOOKUP;
    req_if.address = '0;
    req_if.write_data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.lines_in_use = LINES_IN_USE_RESET;
    errors = 0;
    items_sent = 0;
    rsps_checked = 0;
    hits_seen = 0;
    cfg_writes = 0;
    sender_idle = 0;
    recv_stall = 0;
    hold_left = 0;
    line_valid = '0;
    fill_ptr = 0;
    lines_cfg = LINES_IN_USE_RESET;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        write_lines_in_use(dir_rows[r].cfg_val);
      end else begin
        send_item(dir_rows[r].action, dir_rows[r].address, dir_rows[r].write_data,
                  dir_rows[r].src, dir_rows[r].rsp);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      write_lines_in_use((ph == 3) ? 5'($urandom_range(0, 31)) : phase_lines[ph]);
      sender_idle = send_idle_pct[ph];
      recv_stall = recv_stall_pct[ph];
      foreach (addr_pool[k]) addr_pool[k] = $urandom;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 52) act = ACT_LOOKUP;
        else if (pick < 92) act = ACT_FILL;
        else if (pick < 96) act = ACT_CLEAR;
        else act = ACT_RESERVED;
        pick = $urandom_range(0, 99);
        if (pick < 80) addr = addr_pool[$urandom_range(0, 7)];
        else if (pick < 90) addr = $urandom;
        else addr = pick[0] ? '1 : '0;
        send_item(act, addr, $urandom, BY_MODEL, ZERO_RSP);
        if (ph == PHASES - 1 && i % 55 == 0) hold_left = 40;
      end
    end

    @(negedge clk);
    req_if.valid = 1'b0;

    waited = 0;
    while (expected_rsps.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (6) @(posedge clk);
    if (expected_rsps.size() != 0) begin
      $error("%0d expected results never arrived", expected_rsps.size());
      errors++;
    end

    $display("Covered %0d items and %0d checked results (%0d lookup hits) over %0d",
             items_sent, rsps_checked, hits_seen, cfg_writes);
    $display("lines-in-use settings, with idle, stall and hold-off phases.");
    if (errors == 0) begin
      $display("assoc_data_cache_fifo test passed");
    end else begin
      $display("assoc_data_cache_fifo test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
